>>> src/hrcp_pkg.sv
// Shared types, constants and character helpers for the HTTP response parser.
`default_nettype none
package hrcp_pkg;

	localparam int NUM_W_DEF = 32;
	localparam int TOTAL_W   = 25;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	localparam logic [ADDR_W-1:0]  ADDR_MAX_BODY  = 3'd0;
	localparam logic [TOTAL_W-1:0] MAX_BODY_RESET = 25'd1048576;

	localparam logic [3:0] ERR_OK        = 4'd0;
	localparam logic [3:0] ERR_NO_HEAD   = 4'd1;
	localparam logic [3:0] ERR_NOT_HTTP  = 4'd2;
	localparam logic [3:0] ERR_STATUS    = 4'd3;
	localparam logic [3:0] ERR_SIZE_LINE = 4'd4;
	localparam logic [3:0] ERR_HEX       = 4'd5;
	localparam logic [3:0] ERR_SHORT_CH  = 4'd6;
	localparam logic [3:0] ERR_TOO_LARGE = 4'd7;
	localparam logic [3:0] ERR_LENGTH    = 4'd8;
	localparam logic [3:0] ERR_BODY_SHRT = 4'd9;

	localparam logic [1:0] TRIM_NONE  = 2'd0;
	localparam logic [1:0] TRIM_IN    = 2'd1;
	localparam logic [1:0] TRIM_AFTER = 2'd2;

	localparam logic [1:0] LE_NONE    = 2'd0;
	localparam logic [1:0] LE_CR      = 2'd1;
	localparam logic [1:0] LE_CRLF    = 2'd2;
	localparam logic [1:0] LE_CRLFCR  = 2'd3;

	localparam logic [8*7-1:0]  HTTP_STR = "HTTP/1.";
	localparam logic [8*17-1:0] TE_STR   = "transfer-encoding";
	localparam logic [8*14-1:0] CL_STR   = "content-length";
	localparam logic [8*7-1:0]  CHK_STR  = "chunked";

	localparam logic [7:0] CH_CR = 8'h0d;

	typedef enum logic [7:0] {
		PH_HEAD  = 8'b0000_0001,
		PH_ALL   = 8'b0000_0010,
		PH_LEN   = 8'b0000_0100,
		PH_CSIZE = 8'b0000_1000,
		PH_CDATA = 8'b0001_0000,
		PH_CCR   = 8'b0010_0000,
		PH_CLF   = 8'b0100_0000,
		PH_DONE  = 8'b1000_0000
	} phase_t;

	typedef enum logic [4:0] {
		M_STATUS = 5'b00001,
		M_NAME   = 5'b00010,
		M_SKIP   = 5'b00100,
		M_TE     = 5'b01000,
		M_CL     = 5'b10000
	} mode_t;

	typedef enum logic [5:0] {
		ST_PFX     = 6'b000001,
		ST_SP      = 6'b000010,
		ST_DIG     = 6'b000100,
		ST_OK      = 6'b001000,
		ST_NOTHTTP = 6'b010000,
		ST_BAD     = 6'b100000
	} st_t;

	typedef struct packed {
		logic [7:0] raw;
		logic [7:0] low;
		logic       ws;
		logic       cr;
		logic       lf;
		logic       colon;
		logic       semi;
		logic       space;
		logic       dec;
		logic [4:0] hex;
	} cls_t;

	typedef struct packed {
		logic eos;
		cls_t cls;
	} qent_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t k;
		k.raw   = c;
		k.low   = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
		k.ws    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a) ||
		          (c == 8'h0b) || (c == 8'h0c);
		k.cr    = (c == 8'h0d);
		k.lf    = (c == 8'h0a);
		k.colon = (c == 8'h3a);
		k.semi  = (c == 8'h3b);
		k.space = (c == 8'h20);
		k.dec   = (c >= 8'h30 && c <= 8'h39);
		if (k.dec) begin
			k.hex = 5'(c - 8'h30);
		end else if (k.low >= 8'h61 && k.low <= 8'h66) begin
			k.hex = 5'(k.low - 8'h57);
		end else begin
			k.hex = 5'd16;
		end
		return k;
	endfunction

	function automatic logic [7:0] http_char(input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (i < 3'd7) r = HTTP_STR[8*(6 - int'(i)) +: 8];
		return r;
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (i < 5'd17) r = TE_STR[8*(16 - int'(i)) +: 8];
		return r;
	endfunction

	function automatic logic [7:0] cl_char(input logic [4:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (i < 5'd14) r = CL_STR[8*(13 - int'(i)) +: 8];
		return r;
	endfunction

	function automatic logic [7:0] chk_char(input logic [4:0] i);
		logic [7:0] r;
		r = 8'h00;
		if (i < 5'd7) r = CHK_STR[8*(6 - int'(i)) +: 8];
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/hrcp_front.sv
// Front end: takes input items and classifies each byte for the parser.
`default_nettype none
module hrcp_front
	import hrcp_pkg::*;
(
	input  wire logic       in_valid,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_stream,
	input  wire logic       q_full,
	output logic            in_stall,
	output logic            push,
	output qent_t           push_ent
);

	assign in_stall     = q_full;
	assign push         = in_valid && !q_full;
	assign push_ent.eos = end_of_stream;
	assign push_ent.cls = classify(data_byte);

endmodule
`default_nettype wire

>>> src/hrcp_queue.sv
// Two-entry queue between the classifier and the parser.
`default_nettype none
module hrcp_queue
	import hrcp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t push_ent,
	input  wire logic  pop,
	output logic       full,
	output logic       q_valid,
	output qent_t      q_ent
);

	qent_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_ent   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
`endif

endmodule
`default_nettype wire

>>> src/hrcp_back.sv
// Back end: header/body parser state machine and registered result stage.
`default_nettype none
module hrcp_back
	import hrcp_pkg::*;
#(
	parameter int NUMBER_WIDTH = NUM_W_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire qent_t              q_ent,
	output logic                    pop,
	input  wire logic [TOTAL_W-1:0] max_body,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    is_verdict,
	output logic [7:0]              body_byte,
	output logic [9:0]              status_code,
	output logic [3:0]              err_code
);

	localparam int W = NUMBER_WIDTH;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  trim;
		logic        vbad;
		st_t         st;
		logic [4:0]  idx;
		logic [1:0]  alive;
		logic [1:0]  hseen;
		logic        chunked;
		logic [9:0]  sval;
		logic [1:0]  dcnt;
		logic [W-1:0] num;
		logic        fdig;
		logic        fbad;
		logic        fext;
	} hd_t;

	function automatic hd_t hd_clear();
		hd_t n;
		n.mode    = M_STATUS;
		n.trim    = TRIM_NONE;
		n.vbad    = 1'b0;
		n.st      = ST_PFX;
		n.idx     = 5'd0;
		n.alive   = 2'b11;
		n.hseen   = 2'b00;
		n.chunked = 1'b0;
		n.sval    = 10'd0;
		n.dcnt    = 2'd0;
		n.num     = '0;
		n.fdig    = 1'b0;
		n.fbad    = 1'b0;
		n.fext    = 1'b0;
		return n;
	endfunction

	function automatic hd_t head_char(input hd_t s, input cls_t k);
		hd_t          n;
		logic [9:0]   nv;
		logic [1:0]   al;
		logic [W+3:0] p10;
		n   = s;
		nv  = 10'(s.sval * 10'd10 + {6'd0, k.hex[3:0]});
		al  = s.alive;
		p10 = {4'd0, s.num} * (W+4)'(10) + {{W{1'b0}}, k.hex[3:0]};
		unique case (s.mode)
			M_STATUS: begin
				unique case (s.st)
					ST_PFX: begin
						if (k.raw == http_char(s.idx[2:0])) begin
							n.idx = 5'(s.idx + 5'd1);
							if (s.idx >= 5'd6) n.st = ST_SP;
						end else begin
							n.st = ST_NOTHTTP;
						end
					end
					ST_SP: begin
						if (k.space) begin
							n.st   = ST_DIG;
							n.dcnt = 2'd0;
							n.sval = 10'd0;
						end
					end
					ST_DIG: begin
						if (k.dec) begin
							n.sval = nv;
							n.dcnt = 2'(s.dcnt + 2'd1);
							if (s.dcnt == 2'd2) begin
								n.st = (nv >= 10'd100 && nv <= 10'd599) ? ST_OK : ST_BAD;
							end
						end else begin
							n.st = ST_BAD;
						end
					end
					default: ;
				endcase
			end
			M_NAME: begin
				if (k.colon) begin
					if (s.alive[0] && s.idx == 5'd17) begin
						n.mode = M_TE;
						n.idx  = 5'd0;
						n.vbad = 1'b0;
					end else if (s.alive[1] && s.idx == 5'd14) begin
						n.mode = M_CL;
						n.num  = '0;
						n.fdig = 1'b0;
						n.fbad = 1'b0;
						n.fext = 1'b0;
					end else begin
						n.mode = M_SKIP;
					end
					n.trim = TRIM_NONE;
				end else if (k.ws) begin
					if (s.trim == TRIM_IN) n.trim = TRIM_AFTER;
				end else if (s.trim == TRIM_AFTER) begin
					n.mode = M_SKIP;
				end else begin
					n.trim = TRIM_IN;
					if (s.idx >= 5'd17 || k.low != te_char(s.idx)) al[0] = 1'b0;
					if (s.idx >= 5'd14 || k.low != cl_char(s.idx)) al[1] = 1'b0;
					n.alive = al;
					if (s.idx != 5'd31) n.idx = 5'(s.idx + 5'd1);
					if (al == 2'b00) n.mode = M_SKIP;
				end
			end
			M_TE, M_CL: begin
				if (k.ws) begin
					if (s.trim == TRIM_IN) n.trim = TRIM_AFTER;
				end else if (s.mode == M_TE) begin
					if (s.trim == TRIM_AFTER || s.idx >= 5'd7 || k.low != chk_char(s.idx)) begin
						n.vbad = 1'b1;
					end else begin
						n.idx = 5'(s.idx + 5'd1);
					end
					n.trim = TRIM_IN;
				end else begin
					if (s.trim == TRIM_AFTER || !k.dec) begin
						n.fbad = 1'b1;
					end else begin
						if (p10[W+3:W] != 4'd0) n.fbad = 1'b1;
						else n.num = p10[W-1:0];
						n.fdig = 1'b1;
					end
					n.trim = TRIM_IN;
				end
			end
			default: ;
		endcase
		return n;
	endfunction

	function automatic hd_t head_line_end(input hd_t s);
		hd_t        n;
		logic [1:0] hs;
		n  = s;
		hs = s.hseen;
		unique case (s.mode)
			M_STATUS: begin
				if (s.st == ST_PFX) n.st = ST_NOTHTTP;
				else if (s.st == ST_SP || s.st == ST_DIG) n.st = ST_BAD;
			end
			M_TE: begin
				hs[0]     = 1'b1;
				n.chunked = !s.vbad && (s.idx == 5'd7);
			end
			M_CL: hs[1] = 1'b1;
			default: ;
		endcase
		n.hseen = hs;
		n.alive = ~hs;
		n.mode  = (hs != 2'b11) ? M_NAME : M_SKIP;
		n.trim  = TRIM_NONE;
		n.idx   = 5'd0;
		return n;
	endfunction

	function automatic hd_t size_char(input hd_t s, input cls_t k);
		hd_t n;
		n = s;
		if (!s.fext) begin
			if (k.semi) begin
				n.fext = 1'b1;
			end else if (k.ws) begin
				if (s.trim == TRIM_IN) n.trim = TRIM_AFTER;
			end else begin
				if (s.trim == TRIM_AFTER || k.hex[4]) begin
					n.fbad = 1'b1;
				end else begin
					if (s.num[W-1 -: 4] != 4'd0) n.fbad = 1'b1;
					else n.num = {s.num[W-5:0], k.hex[3:0]};
					n.fdig = 1'b1;
				end
				n.trim = TRIM_IN;
			end
		end
		return n;
	endfunction

	phase_t             phase_q, phase_d;
	hd_t                hd_q, hd_d;
	logic [1:0]         le_q, le_d;
	logic [W-1:0]       rem_q, rem_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic [3:0]         err_q, err_d;
	logic               emit;
	logic               emit_verdict;
	logic [3:0]         v_err;
	logic [W-1:0]       rem_dec;
	cls_t               cr_cls;
	cls_t               k;
	logic               lf_done;

	assign pop     = q_valid && (!out_valid || !out_stall);
	assign k       = q_ent.cls;
	assign cr_cls  = classify(CH_CR);
	assign rem_dec = W'(rem_q - W'(1));

	always_comb begin
		phase_d      = phase_q;
		hd_d         = hd_q;
		le_d         = le_q;
		rem_d        = rem_q;
		total_d      = total_q;
		err_d        = err_q;
		emit         = 1'b0;
		emit_verdict = 1'b0;
		lf_done      = 1'b0;
		v_err        = ERR_OK;
		if (q_ent.eos) begin
			unique case (phase_q)
				PH_HEAD:  v_err = ERR_NO_HEAD;
				PH_LEN:   v_err = (rem_q != '0) ? ERR_BODY_SHRT : ERR_OK;
				PH_CSIZE: v_err = ERR_SIZE_LINE;
				PH_CDATA, PH_CCR, PH_CLF: v_err = ERR_SHORT_CH;
				PH_ALL:   v_err = ERR_OK;
				default:  v_err = err_q;
			endcase
			emit         = 1'b1;
			emit_verdict = 1'b1;
			phase_d      = PH_HEAD;
			hd_d         = hd_clear();
			le_d         = LE_NONE;
			rem_d        = '0;
			total_d      = '0;
			err_d        = ERR_OK;
		end else begin
			unique case (phase_q)
				PH_HEAD: begin
					if (le_q == LE_CR || le_q == LE_CRLFCR) begin
						if (k.lf) begin
							lf_done = 1'b1;
							if (le_q == LE_CR) begin
								hd_d = head_line_end(hd_q);
								le_d = LE_CRLF;
							end else begin
								le_d = LE_NONE;
								if (hd_q.st == ST_NOTHTTP) begin
									err_d = ERR_NOT_HTTP; phase_d = PH_DONE;
								end else if (hd_q.st != ST_OK) begin
									err_d = ERR_STATUS; phase_d = PH_DONE;
								end else if (hd_q.chunked) begin
									hd_d.num  = '0;
									hd_d.fdig = 1'b0;
									hd_d.fbad = 1'b0;
									hd_d.fext = 1'b0;
									hd_d.trim = TRIM_NONE;
									phase_d   = PH_CSIZE;
								end else if (hd_q.hseen[1]) begin
									if (hd_q.fdig && !hd_q.fbad) begin
										rem_d   = hd_q.num;
										phase_d = (hd_q.num != '0) ? PH_LEN : PH_DONE;
									end else begin
										err_d = ERR_LENGTH; phase_d = PH_DONE;
									end
								end else begin
									phase_d = PH_ALL;
								end
							end
						end else begin
							hd_d = head_char(hd_q, cr_cls);
							le_d = LE_NONE;
						end
					end
					if (!lf_done) begin
						if (k.cr) le_d = (le_q == LE_CRLF) ? LE_CRLFCR : LE_CR;
						else begin
							hd_d = head_char(hd_d, k);
							le_d = LE_NONE;
						end
					end
				end
				PH_ALL: emit = 1'b1;
				PH_LEN: begin
					emit  = 1'b1;
					rem_d = rem_dec;
					if (rem_dec == '0) phase_d = PH_DONE;
				end
				PH_CSIZE: begin
					if (le_q == LE_CR) begin
						le_d = LE_NONE;
						if (k.lf) begin
							lf_done = 1'b1;
							if (hd_q.fbad || !hd_q.fdig) begin
								err_d = ERR_HEX; phase_d = PH_DONE;
							end else if (hd_q.num == '0) begin
								phase_d = PH_DONE;
							end else begin
								rem_d   = hd_q.num;
								phase_d = PH_CDATA;
							end
						end else begin
							hd_d = size_char(hd_q, cr_cls);
						end
					end
					if (!lf_done) begin
						if (k.cr) le_d = LE_CR;
						else hd_d = size_char(hd_d, k);
					end
				end
				PH_CDATA: begin
					emit  = 1'b1;
					rem_d = rem_dec;
					if (total_q != '1) total_d = TOTAL_W'(total_q + TOTAL_W'(1));
					if (rem_dec == '0) phase_d = PH_CCR;
				end
				PH_CCR: begin
					if (k.cr) phase_d = PH_CLF;
					else begin
						err_d = ERR_SHORT_CH; phase_d = PH_DONE;
					end
				end
				PH_CLF: begin
					if (!k.lf) begin
						err_d = ERR_SHORT_CH; phase_d = PH_DONE;
					end else if (total_q > max_body) begin
						err_d = ERR_TOO_LARGE; phase_d = PH_DONE;
					end else begin
						hd_d.num  = '0;
						hd_d.fdig = 1'b0;
						hd_d.fbad = 1'b0;
						hd_d.fext = 1'b0;
						hd_d.trim = TRIM_NONE;
						le_d      = LE_NONE;
						phase_d   = PH_CSIZE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEAD;
			hd_q      <= hd_clear();
			le_q      <= LE_NONE;
			rem_q     <= '0;
			total_q   <= '0;
			err_q     <= ERR_OK;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				hd_q    <= hd_d;
				le_q    <= le_d;
				rem_q   <= rem_d;
				total_q <= total_d;
				err_q   <= err_d;
			end
			if (pop && emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			is_verdict  <= emit_verdict;
			body_byte   <= emit_verdict ? 8'd0 : k.raw;
			status_code <= (emit_verdict && v_err == ERR_OK) ? hd_q.sval : 10'd0;
			err_code    <= emit_verdict ? v_err : ERR_OK;
		end
	end

`ifndef SYNTHESIS
	a_err_zero_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_verdict && err_code != ERR_OK) |-> status_code == 10'd0)
		else $error("error verdict carries a status");
	a_body_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_verdict) |-> (status_code == 10'd0 && err_code == ERR_OK))
		else $error("body item carries verdict fields");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_ent.eos) |=> phase_q == PH_HEAD)
		else $error("no restart after verdict");
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_OK) |-> phase_q == PH_DONE)
		else $error("latched error outside done phase");
`endif

endmodule
`default_nettype wire

>>> src/http_response_chunked_parser.sv
// Top level of the streaming HTTP/1.x response parser with chunked decoding.
// One response byte per input item, one item per cycle while out_stall holds
// no result: each item goes through a byte classifier, a two-entry queue and
// the parser state machine, which consumes one queued item per cycle into a
// registered result stage. An item is written into the queue, then taken by
// the parser, which registers its result; out_valid stays high until out_stall
// is low. While out_stall holds a result, the queue fills to two entries before
// in_stall rises. An end_of_stream item yields the verdict and restarts parsing
// for the next response. The APB register at address 0 holds max_body_bytes.
`default_nettype none
module http_response_chunked_parser
	import hrcp_pkg::*;
#(
	parameter int NUMBER_WIDTH = NUM_W_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_stream,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   is_verdict,
	output logic [7:0]             body_byte,
	output logic [9:0]             status_code,
	output logic [3:0]             err_code,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic               max_wr;
	logic [TOTAL_W-1:0] max_body_q;
	logic               q_full;
	logic               push;
	qent_t              push_ent;
	logic               q_valid;
	qent_t              q_ent;
	logic               pop;

	assign pready = 1'b1;
	assign max_wr = psel && penable && pwrite && (paddr == ADDR_MAX_BODY);
	assign prdata = (paddr == ADDR_MAX_BODY) ? DATA_W'(max_body_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MAX_BODY_RESET;
		end else if (max_wr) begin
			max_body_q <= pwdata[TOTAL_W-1:0];
		end
	end

	hrcp_front u_front (
		.in_valid      (in_valid),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.q_full        (q_full),
		.in_stall      (in_stall),
		.push          (push),
		.push_ent      (push_ent)
	);

	hrcp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_ent    (q_ent)
	);

	hrcp_back #(
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ent       (q_ent),
		.pop         (pop),
		.max_body    (max_body_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.is_verdict  (is_verdict),
		.body_byte   (body_byte),
		.status_code (status_code),
		.err_code    (err_code)
	);

endmodule
`default_nettype wire

>>> tb/tb_http_response_chunked_parser.sv
// Self-checking testbench for http_response_chunked_parser: directed and random responses.
`default_nettype none
module tb_http_response_chunked_parser;
	import hrcp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       verdict;
		logic [7:0] body;
		logic [9:0] status;
		logic [3:0] err;
	} resp_item_t;

	localparam int STATUS_LINE = 0;
	localparam int NAME_LINE   = 1;
	localparam int SKIP_LINE   = 2;
	localparam int TE_LINE     = 3;
	localparam int CL_LINE     = 4;
	localparam int P_HEAD  = 0;
	localparam int P_ALL   = 1;
	localparam int P_LEN   = 2;
	localparam int P_CSIZE = 3;
	localparam int P_CDATA = 4;
	localparam int P_CCR   = 5;
	localparam int P_CLF   = 6;
	localparam int P_DONE  = 7;
	localparam logic [2:0] NF_DIGIT = 3'd1;
	localparam logic [2:0] NF_BAD   = 3'd2;
	localparam logic [2:0] NF_EXT   = 3'd4;
	localparam logic [63:0] NUM_LIMIT = 64'hFFFF_FFFF;
	localparam logic [24:0] BODY_SAT  = 25'h1FF_FFFF;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] data_byte = '0;
	logic end_of_stream = 1'b0;
	logic out_stall = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	wire in_stall, out_valid, is_verdict, pready;
	wire [7:0] body_byte;
	wire [9:0] status_code;
	wire [3:0] err_code;
	wire [DATA_W-1:0] prdata;

	http_response_chunked_parser u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_stream(end_of_stream), .out_valid(out_valid),
		.out_stall(out_stall), .is_verdict(is_verdict), .body_byte(body_byte),
		.status_code(status_code), .err_code(err_code), .psel(psel),
		.penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	int phase, lmode, trim, vbad, sstate, lidx, alive, hseen, chunked;
	int status_val, digits, let_trk, lerr;
	logic [63:0] numv, remain;
	logic [2:0] nflags;
	logic [24:0] total, max_body;

	resp_item_t expected_q[$];
	int mismatches = 0;
	int cycles = 0;
	bit idle_on = 1'b1;
	bit timed_out = 1'b0;

	function automatic bit is_space_char(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a || c == 8'h0b || c == 8'h0c;
	endfunction

	function automatic logic [7:0] lc(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic int hexv(logic [7:0] c);
		logic [7:0] l;
		l = lc(c);
		if (c >= "0" && c <= "9") return c - "0";
		if (l >= "a" && l <= "f") return l - "a" + 10;
		return 16;
	endfunction

	function automatic logic [7:0] str_at(string s, int i);
		return (i < s.len()) ? s[i] : 8'h00;
	endfunction

	task automatic clear_parse();
		phase = P_HEAD; lmode = STATUS_LINE; trim = 0; vbad = 0; sstate = 0;
		lidx = 0; alive = 3; hseen = 0; chunked = 0; status_val = 0; digits = 0;
		numv = 0; nflags = 0; remain = 0; total = 0; let_trk = 0; lerr = 0;
	endtask

	task automatic add_digit(int d, int base);
		if (numv > (NUM_LIMIT - d) / base) nflags |= NF_BAD;
		else numv = numv * base + d;
		nflags |= NF_DIGIT;
	endtask

	task automatic latch_err(int e);
		lerr = e;
		phase = P_DONE;
	endtask

	task automatic head_content(logic [7:0] c);
		case (lmode)
			STATUS_LINE: begin
				if (sstate == 0) begin
					if (c == str_at("HTTP/1.", lidx % 8)) begin
						lidx++;
						if (lidx >= 7) sstate = 1;
					end else sstate = 4;
				end else if (sstate == 1) begin
					if (c == " ") begin
						sstate = 2; digits = 0; status_val = 0;
					end
				end else if (sstate == 2) begin
					if (c >= "0" && c <= "9") begin
						status_val = status_val * 10 + (c - "0");
						digits++;
						if (digits >= 3) sstate = (status_val >= 100 && status_val <= 599) ? 3 : 5;
					end else sstate = 5;
				end
			end
			NAME_LINE: begin
				if (c == ":") begin
					if ((alive & 1) && lidx == 17) begin
						lmode = TE_LINE; lidx = 0; vbad = 0;
					end else if ((alive & 2) && lidx == 14) begin
						lmode = CL_LINE; numv = 0; nflags = 0;
					end else lmode = SKIP_LINE;
					trim = 0;
				end else if (is_space_char(c)) begin
					if (trim == 1) trim = 2;
				end else if (trim == 2) begin
					lmode = SKIP_LINE;
				end else begin
					trim = 1;
					if (lidx >= 17 || lc(c) != str_at("transfer-encoding", lidx)) alive &= 2;
					if (lidx >= 14 || lc(c) != str_at("content-length", lidx)) alive &= 1;
					if (lidx < 31) lidx++;
					if (alive == 0) lmode = SKIP_LINE;
				end
			end
			TE_LINE, CL_LINE: begin
				if (is_space_char(c)) begin
					if (trim == 1) trim = 2;
				end else if (lmode == TE_LINE) begin
					if (trim == 2 || lidx >= 7 || lc(c) != str_at("chunked", lidx)) vbad = 1;
					else lidx++;
					trim = 1;
				end else begin
					if (trim == 2 || c < "0" || c > "9") nflags |= NF_BAD;
					else add_digit(c - "0", 10);
					trim = 1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic head_line_done();
		if (lmode == STATUS_LINE) begin
			if (sstate == 0) sstate = 4;
			else if (sstate == 1 || sstate == 2) sstate = 5;
		end else if (lmode == TE_LINE) begin
			hseen |= 1;
			chunked = (!vbad && lidx == 7);
		end else if (lmode == CL_LINE) hseen |= 2;
		alive = ~hseen & 3;
		lmode = alive ? NAME_LINE : SKIP_LINE;
		trim = 0;
		lidx = 0;
	endtask

	task automatic begin_size_line();
		numv = 0; nflags = 0; trim = 0; let_trk = 0; phase = P_CSIZE;
	endtask

	task automatic head_done();
		let_trk = 0;
		if (sstate == 4) latch_err(ERR_NOT_HTTP);
		else if (sstate != 3) latch_err(ERR_STATUS);
		else if (chunked) begin_size_line();
		else if (hseen & 2) begin
			if ((nflags & NF_DIGIT) && !(nflags & NF_BAD)) begin
				remain = numv;
				phase = remain ? P_LEN : P_DONE;
			end else latch_err(ERR_LENGTH);
		end else phase = P_ALL;
	endtask

	task automatic size_content(logic [7:0] c);
		int h;
		if (nflags & NF_EXT) return;
		if (c == ";") begin
			nflags |= NF_EXT;
			return;
		end
		if (is_space_char(c)) begin
			if (trim == 1) trim = 2;
			return;
		end
		h = hexv(c);
		if (trim == 2 || h > 15) nflags |= NF_BAD;
		else add_digit(h, 16);
		trim = 1;
	endtask

	// Returns 1 with a result in r when the item produces one.
	task automatic predict_parser(logic [7:0] c, logic eos, output bit has, output resp_item_t r);
		int e;
		has = 1'b0;
		r = '0;
		if (eos) begin
			case (phase)
				P_HEAD: e = ERR_NO_HEAD;
				P_LEN: e = remain ? ERR_BODY_SHRT : ERR_OK;
				P_CSIZE: e = ERR_SIZE_LINE;
				P_CDATA, P_CCR, P_CLF: e = ERR_SHORT_CH;
				P_ALL: e = ERR_OK;
				default: e = lerr;
			endcase
			r.verdict = 1'b1;
			r.status = e ? 10'd0 : 10'(status_val);
			r.err = 4'(e);
			has = 1'b1;
			clear_parse();
			return;
		end
		case (phase)
			P_HEAD: begin
				if (let_trk == 1 || let_trk == 3) begin
					if (c == 8'h0a) begin
						if (let_trk == 1) begin
							head_line_done();
							let_trk = 2;
						end else head_done();
						return;
					end
					head_content(8'h0d);
					let_trk = 0;
				end
				if (c == 8'h0d) let_trk = (let_trk == 2) ? 3 : 1;
				else begin
					head_content(c);
					let_trk = 0;
				end
				return;
			end
			P_ALL: has = 1'b1;
			P_LEN: begin
				remain--;
				if (remain == 0) phase = P_DONE;
				has = 1'b1;
			end
			P_CSIZE: begin
				if (let_trk == 1) begin
					let_trk = 0;
					if (c == 8'h0a) begin
						if ((nflags & NF_BAD) || !(nflags & NF_DIGIT)) latch_err(ERR_HEX);
						else if (numv == 0) phase = P_DONE;
						else begin
							remain = numv;
							phase = P_CDATA;
						end
						return;
					end
					size_content(8'h0d);
				end
				if (c == 8'h0d) let_trk = 1;
				else size_content(c);
				return;
			end
			P_CDATA: begin
				remain--;
				if (total < BODY_SAT) total++;
				if (remain == 0) phase = P_CCR;
				has = 1'b1;
			end
			P_CCR: begin
				if (c == 8'h0d) phase = P_CLF;
				else latch_err(ERR_SHORT_CH);
				return;
			end
			P_CLF: begin
				if (c != 8'h0a) latch_err(ERR_SHORT_CH);
				else if (total > max_body) latch_err(ERR_TOO_LARGE);
				else begin_size_line();
				return;
			end
			default: return;
		endcase
		r.body = c;
	endtask

	task automatic gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic send_byte(logic [7:0] c, logic eos);
		bit has;
		resp_item_t r;
		gap();
		in_valid <= 1'b1;
		data_byte <= c;
		end_of_stream <= eos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_parser(c, eos, has, r);
		if (has) expected_q.push_back(r);
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic finish_response();
		send_byte(8'($urandom), 1'b1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_max_body(logic [24:0] v);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MAX_BODY; pwdata <= DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		max_body = v;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (idle_on && $urandom_range(0, 4) == 0) out_stall <= 1'b1;
		else if (!idle_on || $urandom_range(0, 1)) out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		resp_item_t got, want;
		cycles++;
		if (arst_n && out_valid && !out_stall) begin
			got = {is_verdict, body_byte, status_code, err_code};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected v=%0d b=%h s=%0d e=%0d got v=%0d b=%h s=%0d e=%0d",
							want.verdict, want.body, want.status, want.err,
							got.verdict, got.body, got.status, got.err);
				end
			end
		end
		if (cycles > CYCLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("FAIL http_response_chunked_parser");
			$finish;
		end
	end

	function automatic string rand_body(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom))};
		return s;
	endfunction

	task automatic test_plain_and_length();
		send_text("HTTP/1.1 200 OK\r\nServer: x\r\n\r\n");
		send_text({"ab", 8'h00, 8'hFF});
		finish_response();
		send_text("HTTP/1.0 599 Z\r\n  CONTENT-length :  3 \r\nContent-Length: 9\r\n\r\nxyzqq");
		finish_response();
		send_text("HTTP/1.1 100\r\nContent-Length: 5\r\n\r\nab");
		finish_response();
		send_text("HTTP/1.1 200\r\nContent-Length: 0\r\n\r\nzz");
		finish_response();
		send_text("HTTP/1.1 200\r\nContent-Length: 99999999999\r\n\r\n");
		finish_response();
		send_text("HTTP/1.1 200\r\nContent-Length: 1 2\r\n\r\n");
		finish_response();
	endtask

	task automatic test_head_errors();
		send_text("HTTP/1.1 200 OK\r\n");
		finish_response();
		send_text("HTTX/1.1 200\r\n\r\n");
		finish_response();
		send_text("HTTP/1.1 600\r\n\r\n");
		finish_response();
		send_text("HTTP/1.1 099\r\n\r\n");
		finish_response();
		send_text("HTTP/1.1 2a0\r\n\r\n");
		finish_response();
		send_text("HTTP/1.1\r\n\r\n");
		finish_response();
		send_text({"HTTP/1.1 204 a", 8'h0d, "b", 8'h0a, "c\r\n\r\n"});
		finish_response();
		finish_response();
	endtask

	task automatic test_chunked();
		send_text("HTTP/1.1 200\r\nTransfer-Encoding:  Chunked \r\n\r\n");
		send_text("3;ext=1\r\nabc\r\nA \r\n0123456789\r\n0\r\nleftover");
		finish_response();
		send_text("HTTP/1.1 200\r\nTransfer-Encoding: gzip\r\nTransfer-Encoding: chunked\r\n\r\nq");
		finish_response();
		send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\nzz\r\n");
		finish_response();
		send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n123456789\r\n");
		finish_response();
		send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nabX");
		finish_response();
		send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nab\rX");
		finish_response();
		send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n4\r\nab");
		finish_response();
		send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n1 2\r\n");
		finish_response();
	endtask

	task automatic test_body_limit();
		write_max_body(25'd1);
		send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n1\r\nx\r\n2\r\nyz\r\n0\r\n");
		finish_response();
		write_max_body(25'd16777216);
		send_text("HTTP/1.1 201\r\nTransfer-Encoding: chunked\r\n\r\nf\r\n0123456789abcde\r\n0\r\n");
		finish_response();
		write_max_body(25'd4);
		send_text("HTTP/1.1 201\r\nTransfer-Encoding: chunked\r\n\r\n4\r\nabcd\r\n1\r\ne\r\n");
		finish_response();
	endtask

	task automatic random_response();
		int kind, n, chunks;
		string s;
		kind = $urandom_range(0, 9);
		s = $sformatf("HTTP/1.%0d %0d X\r\n", $urandom_range(0, 1), $urandom_range(80, 620));
		if ($urandom_range(0, 2) == 0) s = {s, "Host: a\r\n"};
		if (kind == 0) begin
			send_text(rand_body($urandom_range(1, 30)));
			if ($urandom_range(0, 1)) send_text("\r\n\r\n");
			send_text(rand_body($urandom_range(0, 8)));
		end else if (kind <= 3) begin
			n = $urandom_range(0, 12);
			send_text({s, $sformatf("Content-Length: %0d\r\n\r\n", n)});
			send_text(rand_body($urandom_range(0, 16)));
		end else if (kind <= 8) begin
			send_text({s, "transfer-encoding: chunked\r\n\r\n"});
			chunks = $urandom_range(0, 3);
			for (int i = 0; i < chunks; i++) begin
				n = $urandom_range(1, 20);
				send_text({$sformatf($urandom_range(0, 1) ? "%0x" : "%0X", n),
					$urandom_range(0, 3) == 0 ? ";e" : "", "\r\n", rand_body(n)});
				if ($urandom_range(0, 9) == 0) send_text(rand_body(2));
				else send_text("\r\n");
			end
			if ($urandom_range(0, 3) != 0) send_text("0\r\n");
		end else begin
			send_text({s, "\r\n", rand_body($urandom_range(0, 20))});
		end
		finish_response();
	endtask

	task automatic test_random();
		write_max_body(25'd30);
		for (int i = 0; i < 4; i++) random_response();
		drain();
		write_max_body(25'd1048576);
		for (int i = 0; i < 4; i++) random_response();
		idle_on = 1'b0;
		for (int i = 0; i < 2; i++) random_response();
	endtask

	initial begin
		clear_parse();
		max_body = MAX_BODY_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_plain_and_length();
		test_head_errors();
		test_chunked();
		test_body_limit();
		test_random();
		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("PASS http_response_chunked_parser");
		end else begin
			$display("FAIL http_response_chunked_parser");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
src/hrcp_pkg.sv
src/hrcp_front.sv
src/hrcp_queue.sv
src/hrcp_back.sv
src/http_response_chunked_parser.sv
tb/tb_http_response_chunked_parser.sv
